// File: design/barometer_sensor_compensation_macros.svh
// assertion helpers shared by the compensation block
`ifndef BAROMETER_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETER_SENSOR_COMPENSATION_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define BSC_ASSERT_IMP(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define BSC_ASSERT_NXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: design/bsc_pkg.sv
package bsc_pkg;

    // calibration register index, from paddr[3:2]
    typedef enum logic [1:0] {
        REG_CAL_ONE   = 2'd0,
        REG_CAL_TWO   = 2'd1,
        REG_CAL_THREE = 2'd2,
        REG_CAL_FOUR  = 2'd3
    } t_reg_idx;

    // coefficients unpacked from the calibration words
    typedef struct packed {
        logic [14:0] c1;
        logic [11:0] c2;
        logic [9:0]  c3;
        logic [9:0]  c4;
        logic [10:0] c5;
        logic [5:0]  c6;
    } t_coef;

    // word handed from the temperature/coefficient stages to the pressure stages
    typedef struct packed {
        logic        valid;
        logic [13:0] temp;
        logic [15:0] off;
        logic [17:0] sens;
        logic [16:0] dp;
    } t_front_bus;

    // fixed terms of the compensation
    localparam logic [15:0] UT1_OFS    = 16'd20224;
    localparam logic [16:0] D1_OFS     = 17'd7168;
    localparam logic [10:0] C4_OFS     = 11'd512;
    localparam logic [6:0]  C6_OFS     = 7'd50;
    localparam logic [15:0] TEMP_BASE  = 16'd200;
    localparam logic [18:0] SENS_OFS   = 19'd24576;
    localparam logic [20:0] P_BASE     = 21'd2500;

endpackage

// File: design/bsc_cfg.sv
`include "barometer_sensor_compensation_macros.svh"

module bsc_cfg
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_coef       o_coef
);

    logic [15:0] r_cal_one;
    logic [15:0] r_cal_two;
    logic [15:0] r_cal_three;
    logic [15:0] r_cal_four;
    logic        n_wr;
    t_reg_idx    n_idx;

    assign pready = 1'b1;
    assign n_wr   = psel && penable && pwrite && pready;
    assign n_idx  = t_reg_idx'(paddr[3:2]);

    // calibration word writes, low 16 bits kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_one   <= '0;
            r_cal_two   <= '0;
            r_cal_three <= '0;
            r_cal_four  <= '0;
        end else if (n_wr) begin
            unique case (n_idx)
                REG_CAL_ONE:   r_cal_one   <= pwdata[15:0];
                REG_CAL_TWO:   r_cal_two   <= pwdata[15:0];
                REG_CAL_THREE: r_cal_three <= pwdata[15:0];
                REG_CAL_FOUR:  r_cal_four  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (n_idx)
            REG_CAL_ONE:   prdata = {16'h0000, r_cal_one};
            REG_CAL_TWO:   prdata = {16'h0000, r_cal_two};
            REG_CAL_THREE: prdata = {16'h0000, r_cal_three};
            REG_CAL_FOUR:  prdata = {16'h0000, r_cal_four};
            default:       prdata = '0;
        endcase
    end

    // coefficient unpacking
    assign o_coef.c1 = r_cal_one[15:1];
    assign o_coef.c2 = {r_cal_three[5:0], r_cal_four[5:0]};
    assign o_coef.c3 = r_cal_four[15:6];
    assign o_coef.c4 = r_cal_three[15:6];
    assign o_coef.c5 = {r_cal_one[0], r_cal_two[15:6]};
    assign o_coef.c6 = r_cal_two[5:0];

    `BSC_ASSERT_NXT(a_cal_one_wr, n_wr && (n_idx == REG_CAL_ONE), o_coef.c1 == $past(pwdata[15:1]), "c1 not taken from first calibration word")

endmodule

// File: design/bsc_front.sv
`include "barometer_sensor_compensation_macros.svh"

module bsc_front
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_d1,
    input  logic [15:0] i_d2,
    input  t_coef       i_coef,
    output t_front_bus  o_bus,
    input  logic        i_ready
);

    logic               r_v1, r_v2, r_v3;
    logic               n_rdy1, n_rdy2, n_rdy3;
    logic [15:0]        n_ut1;
    logic signed [17:0] n_dt;
    logic signed [16:0] n_dp;
    logic signed [17:0] r_dt;
    logic signed [16:0] r_dp1, r_dp2, r_dp3;
    logic [6:0]         n_c6p;
    logic signed [10:0] n_c4m;
    logic signed [25:0] n_mt, r_mt;
    logic signed [28:0] n_mo, r_mo;
    logic signed [28:0] n_ms, r_ms;
    logic signed [15:0] n_temp;
    logic signed [16:0] n_off;
    logic signed [18:0] n_sens;
    logic [13:0]        r_temp;
    logic [15:0]        r_off;
    logic [17:0]        r_sens;

    // per-stage ready chain
    assign n_rdy3  = !r_v3 || i_ready;
    assign n_rdy2  = !r_v2 || n_rdy3;
    assign n_rdy1  = !r_v1 || n_rdy2;
    assign o_ready = n_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (n_rdy1) r_v1 <= i_valid;
            if (n_rdy2) r_v2 <= r_v1;
            if (n_rdy3) r_v3 <= r_v2;
        end
    end

    // stage 1: temperature difference and pressure offset
    assign n_ut1 = {2'b00, i_coef.c5, 3'b000} + UT1_OFS;
    assign n_dt  = $signed({2'b00, i_d2}) - $signed({2'b00, n_ut1});
    assign n_dp  = $signed({1'b0, i_d1}) - $signed(D1_OFS);

    always_ff @(posedge i_clk) begin
        if (n_rdy1) begin
            r_dt  <= n_dt;
            r_dp1 <= n_dp;
        end
    end

    // stage 2: three products with dT
    assign n_c6p = {1'b0, i_coef.c6} + C6_OFS;
    assign n_c4m = $signed({1'b0, i_coef.c4}) - $signed(C4_OFS);
    assign n_mt  = 26'(r_dt) * 26'($signed({1'b0, n_c6p}));
    assign n_mo  = 29'(r_dt) * 29'(n_c4m);
    assign n_ms  = 29'(r_dt) * 29'($signed({1'b0, i_coef.c3}));

    always_ff @(posedge i_clk) begin
        if (n_rdy2) begin
            r_mt  <= n_mt;
            r_mo  <= n_mo;
            r_ms  <= n_ms;
            r_dp2 <= r_dp1;
        end
    end

    // stage 3: floor shifts and the temperature, offset and sensitivity sums
    assign n_temp = $signed(r_mt[25:10]) + $signed(TEMP_BASE);
    assign n_off  = $signed({3'b000, i_coef.c2, 2'b00}) + $signed(r_mo[28:12]);
    assign n_sens = $signed({4'b0000, i_coef.c1}) + $signed(SENS_OFS)
                  + $signed(r_ms[28:10]);

    always_ff @(posedge i_clk) begin
        if (n_rdy3) begin
            r_temp <= n_temp[13:0];
            r_off  <= n_off[15:0];
            r_sens <= n_sens[17:0];
            r_dp3  <= r_dp2;
        end
    end

    assign o_bus.valid = r_v3;
    assign o_bus.temp  = r_temp;
    assign o_bus.off   = r_off;
    assign o_bus.sens  = r_sens;
    assign o_bus.dp    = r_dp3;

    `BSC_ASSERT_NXT(a_front_hold, r_v3 && !i_ready, r_v3, "front word lost while back stalled")

endmodule

// File: design/bsc_back.sv
module bsc_back
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_front_bus  i_bus,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [13:0] o_temp,
    output logic [17:0] o_pres
);

    logic               r_v4, r_v5;
    logic               n_rdy4, n_rdy5;
    logic signed [34:0] n_prod, r_prod;
    logic [13:0]        r_temp4, r_temp5;
    logic [15:0]        r_off;
    logic signed [21:0] n_x;
    logic signed [25:0] n_x10;
    logic signed [20:0] n_p;
    logic [17:0]        r_pres;

    // per-stage ready chain, stage 5 is the output register
    assign n_rdy5  = !r_v5 || i_ready;
    assign n_rdy4  = !r_v4 || n_rdy5;
    assign o_ready = n_rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (n_rdy4) r_v4 <= i_bus.valid;
            if (n_rdy5) r_v5 <= r_v4;
        end
    end

    // stage 4: sensitivity times pressure offset
    assign n_prod = 35'($signed(i_bus.sens)) * 35'($signed(i_bus.dp));

    always_ff @(posedge i_clk) begin
        if (n_rdy4) begin
            r_prod  <= n_prod;
            r_temp4 <= i_bus.temp;
            r_off   <= i_bus.off;
        end
    end

    // stage 5: remove offset, scale by ten with shift-add, final floor shift
    assign n_x   = 22'($signed(r_prod[34:14])) - 22'($signed(r_off));
    assign n_x10 = (26'(n_x) <<< 3) + (26'(n_x) <<< 1);
    assign n_p   = $signed(n_x10[25:5]) + $signed(P_BASE);

    always_ff @(posedge i_clk) begin
        if (n_rdy5) begin
            r_temp5 <= r_temp4;
            r_pres  <= n_p[17:0];
        end
    end

    assign o_valid = r_v5;
    assign o_temp  = r_temp5;
    assign o_pres  = r_pres;

endmodule

// File: design/barometer_sensor_compensation.sv
// Barometric sensor compensation: takes a raw pressure count and a raw temperature
// count per input word and returns temperature in tenths of a degree Celsius and
// pressure in tenths of a millibar, using six coefficients unpacked from four
// calibration words written over the APB port. The datapath is a five-stage
// pipeline (temperature difference, three dT products, coefficient sums,
// sensitivity-times-pressure product, final offset and scaling) that accepts one
// word every clock while no stall reaches the input; the stage count follows the
// two multiplier ranks in series. Every stage has its own valid bit, so bubbles
// are filled while the output waits and back-pressure on m_tready stalls the
// pipeline without losing or repeating a word. Calibration words must be written
// while the pipeline is empty.
`include "barometer_sensor_compensation_macros.svh"

module barometer_sensor_compensation
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] pressure_raw, [31:16] temperature_raw
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [13:0] temperature_tenths, [31:14] pressure_tenths
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_coef       w_coef;
    t_front_bus  w_bus;
    logic        w_back_ready;
    logic [13:0] w_temp;
    logic [17:0] w_pres;

    // calibration registers
    bsc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coef  (w_coef)
    );

    // temperature and coefficient stages
    bsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_d1    (s_tdata[15:0]),
        .i_d2    (s_tdata[31:16]),
        .i_coef  (w_coef),
        .o_bus   (w_bus),
        .i_ready (w_back_ready)
    );

    // pressure stages and output register
    bsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bus   (w_bus),
        .o_ready (w_back_ready),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_temp  (w_temp),
        .o_pres  (w_pres)
    );

    assign m_tdata = {w_pres, w_temp};

    `BSC_ASSERT_IMP(a_empty_out_ready, !m_tvalid, s_tready, "input stalled with empty output")
    `BSC_ASSERT_NXT(a_cfg_ready, psel && !penable, pready, "apb access not completed")

endmodule

// File: tb/sv/compensation_checker.sv
// watches both streams and the config port, predicts each compensated reading
// and compares it against what the block returns
module compensation_checker
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] pressure_raw, [31:16] temperature_raw
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [13:0] temperature_tenths, [31:14] pressure_tenths
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    // fixed terms of the compensation
    localparam longint REF_TEMP_OFS   = 20224;
    localparam longint TEMP_BASE_C    = 200;
    localparam longint TCO_SPAN       = 50;
    localparam longint C4_CENTER      = 512;
    localparam longint SENS_BASE_C    = 24576;
    localparam longint D1_CENTER      = 7168;
    localparam longint PRES_BASE_C    = 2500;

    typedef struct packed {
        logic signed [13:0] temp;
        logic signed [17:0] pres;
    } t_reading;

    logic [15:0] cal_word [4];
    t_reading    expected_readings [$];

    // compensated temperature and pressure for one raw sample pair
    function automatic t_reading compensate(input logic [15:0] d1_raw,
                                            input logic [15:0] d2_raw);
        longint   c1, c2, c3, c4, c5, c6;
        longint   d1, d2, dt, temp, off, sens, x, p;
        t_reading r;
        c1   = cal_word[REG_CAL_ONE][15:1];
        c2   = {cal_word[REG_CAL_THREE][5:0], cal_word[REG_CAL_FOUR][5:0]};
        c3   = cal_word[REG_CAL_FOUR][15:6];
        c4   = cal_word[REG_CAL_THREE][15:6];
        c5   = {cal_word[REG_CAL_ONE][0], cal_word[REG_CAL_TWO][15:6]};
        c6   = cal_word[REG_CAL_TWO][5:0];
        d1   = d1_raw;
        d2   = d2_raw;
        dt   = d2 - (8 * c5 + REF_TEMP_OFS);
        temp = TEMP_BASE_C + ((dt * (c6 + TCO_SPAN)) >>> 10);
        off  = 4 * c2 + (((c4 - C4_CENTER) * dt) >>> 12);
        sens = c1 + SENS_BASE_C + ((c3 * dt) >>> 10);
        x    = ((sens * (d1 - D1_CENTER)) >>> 14) - off;
        p    = PRES_BASE_C + ((x * 10) >>> 5);
        r.temp = temp[13:0];
        r.pres = p[17:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            foreach (cal_word[i]) cal_word[i] = '0;
            expected_readings.delete();
            o_fail_count = 0;
        end else begin
            // calibration writes and read-back
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    cal_word[t_reg_idx'(i_paddr[3:2])] = i_pwdata[15:0];
                end else if (i_prdata[15:0] !== cal_word[t_reg_idx'(i_paddr[3:2])]) begin
                    o_fail_count++;
                    $display("%0t: cal read at %0d: expected %h, got %h", $time,
                             i_paddr, cal_word[t_reg_idx'(i_paddr[3:2])], i_prdata[15:0]);
                end
            end
            // result word against oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got.temp = i_m_tdata[13:0];
                got.pres = i_m_tdata[31:14];
                if (expected_readings.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result: expected none, got temp %0d pres %0d",
                             $time, got.temp, got.pres);
                end else begin
                    want = expected_readings.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        $display("%0t: mismatch: expected temp %0d pres %0d, got temp %0d pres %0d",
                                 $time, want.temp, want.pres, got.temp, got.pres);
                    end
                end
            end
            // new sample word
            if (i_s_tvalid && i_s_tready) begin
                expected_readings.push_back(compensate(i_s_tdata[15:0], i_s_tdata[31:16]));
            end
        end
        o_pending = expected_readings.size();
    end

endmodule

// File: tb/sv/testbench.sv
module testbench;
    import bsc_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 228;
    localparam int HOLD_PHASE      = 3;
    localparam int DRAIN_PHASE     = 5;
    localparam int HOLD_CYCLES     = 400;
    localparam int IDLE_LIMIT      = 4000;
    localparam int SETTLE_CYCLES   = 20;
    localparam logic [15:0] D1_CENTER = 16'd7168;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [15:0] pressure_raw, [31:16] temperature_raw
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [13:0] temperature_tenths, [31:14] pressure_tenths
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    logic [15:0] cal_words [4] = '{default: '0};
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    bit          hold_req  = 1'b0;
    bit          burst_on  = 1'b0;
    int          idle_cycles = 0;

    barometer_sensor_compensation u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    compensation_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL barometer_sensor_compensation");
            $finish;
        end
    end

    // result side: random stalls, long hold-off on request
    initial begin : result_sink
        int n;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // one apb transfer, write or read, starting at a rising edge
    task automatic cal_access(input bit wr, input t_reg_idx idx, input logic [15:0] value);
        logic rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = pready;
            @(posedge i_clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (wr) cal_words[idx] = value;
    endtask

    // write all four calibration words and read them back
    task automatic load_cal(input logic [15:0] w1, input logic [15:0] w2,
                            input logic [15:0] w3, input logic [15:0] w4);
        cal_access(1'b1, REG_CAL_ONE, w1);
        cal_access(1'b1, REG_CAL_TWO, w2);
        cal_access(1'b1, REG_CAL_THREE, w3);
        cal_access(1'b1, REG_CAL_FOUR, w4);
        cal_access(1'b0, REG_CAL_ONE, '0);
        cal_access(1'b0, REG_CAL_TWO, '0);
        cal_access(1'b0, REG_CAL_THREE, '0);
        cal_access(1'b0, REG_CAL_FOUR, '0);
    endtask

    // offer one sample pair and hold it until taken
    task automatic send_sample(input logic [15:0] d1, input logic [15:0] d2);
        logic rdy;
        s_tvalid <= 1'b1;
        s_tdata  <= {d2, d1};
        do begin
            @(negedge i_clk);
            rdy = s_tready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    // random sender gap
    task automatic maybe_gap();
        int n;
        if (!tx_steady && !burst_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding reading
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // temperature count at which dT is zero for the current calibration
    function automatic logic [15:0] zero_dt_point();
        return 16'({cal_words[REG_CAL_ONE][0], cal_words[REG_CAL_TWO][15:6]}) * 16'd8
               + 16'd20224;
    endfunction

    function automatic logic [15:0] pick_pressure();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return D1_CENTER + 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_temperature();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return zero_dt_point() + 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // extremes of both counts around the dT zero point
    task automatic send_corners();
        logic [15:0] d1s [3];
        logic [15:0] d2s [3];
        d1s = '{16'h0000, D1_CENTER, 16'hFFFF};
        d2s = '{16'h0000, zero_dt_point(), 16'hFFFF};
        foreach (d1s[i]) begin
            foreach (d2s[j]) send_sample(d1s[i], d2s[j]);
        end
    endtask

    function automatic logic [15:0] pick_cal_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int ph;
        int k;
        bit last_phase;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset calibration, then both extremes and a typical set
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF);
        drain_results();
        load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_corners();
        drain_results();
        load_cal(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'hFFFF);
        send_sample(16'hFFFF, 16'h0000);
        drain_results();
        load_cal(16'hB3B4, 16'h8C2E, 16'hBE4D, 16'h9E2A);
        send_corners();

        // random phases, each with its own calibration
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            if (ph == 0) begin
                load_cal(16'h0000, 16'h0000, 16'h0000, 16'h0000);
            end else if (ph == 1) begin
                load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            end else begin
                load_cal(pick_cal_word(), pick_cal_word(), pick_cal_word(), pick_cal_word());
            end
            last_phase = (ph == NUM_PHASES - 1);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 40 == 0) begin
                    tx_steady = last_phase || ($urandom_range(0, 2) == 0);
                    rx_steady = last_phase || ($urandom_range(0, 2) == 0);
                end
                // long receiver hold-off while samples keep coming
                if (ph == HOLD_PHASE && k == 50) begin
                    hold_req = 1'b1;
                    burst_on = 1'b1;
                end
                if (ph == HOLD_PHASE && k == 130) burst_on = 1'b0;
                if (ph == DRAIN_PHASE && k == 100) drain_results();
                send_sample(pick_pressure(), pick_temperature());
                maybe_gap();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS barometer_sensor_compensation");
        end else begin
            $display("FAIL barometer_sensor_compensation");
        end
        $finish;
    end

endmodule

// File: barometer_sensor_compensation.f
+incdir+design
design/bsc_pkg.sv
design/bsc_cfg.sv
design/bsc_front.sv
design/bsc_back.sv
design/barometer_sensor_compensation.sv
tb/sv/compensation_checker.sv
tb/sv/testbench.sv
